/* rtl/core/ccv_pkg.sv */
// ccv_pkg: shared constants and types for the column vote core.
// Vote slot indices, input and result symbol codes, result record type.
// No dependencies.
package ccv_pkg;

	localparam int MAX_FAMILY_DEF = 255;

	// vote slot order
	localparam int VOTE_A     = 0;
	localparam int VOTE_C     = 1;
	localparam int VOTE_G     = 2;
	localparam int VOTE_T     = 3;
	localparam int VOTE_N     = 4;
	localparam int VOTE_D     = 5;
	localparam int VOTE_I     = 6;
	localparam int VOTE_COUNT = 7;

	// reference base codes
	localparam logic [2:0] REF_A = 3'd1;
	localparam logic [2:0] REF_C = 3'd2;
	localparam logic [2:0] REF_G = 3'd3;
	localparam logic [2:0] REF_T = 3'd4;

	// consensus symbol codes
	localparam logic [2:0] SYM_A   = 3'd0;
	localparam logic [2:0] SYM_C   = 3'd1;
	localparam logic [2:0] SYM_G   = 3'd2;
	localparam logic [2:0] SYM_T   = 3'd3;
	localparam logic [2:0] SYM_N   = 3'd4;
	localparam logic [2:0] SYM_GAP = 3'd5;

	typedef struct packed {
		logic [7:0] winning_votes;
		logic [2:0] consensus_symbol;
	} ccv_result_t;

endpackage

/* rtl/core/consensus_column_vote_core.sv */
// consensus_column_vote_core: majority-vote consensus, one symbol per column.
// Seven saturating vote counters, max search, reference bias, priority pick.
// Depends on ccv_pkg.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata[2:0] base_code, [5:3] ref_code, tlast column_end
// m_*       out  m_tvalid/m_tready  tdata[2:0] consensus_symbol, [10:3] winning_votes
//
// One symbol per cycle while s_tready is high. The counter update, seven-way
// maximum and priority pick sit between the input transfer and the result
// register; a stalled output parks the result in the skid register instead.
// A result register plus a skid register part the two sides; s_tready is a
// register output and drops only while the skid register holds a result.
// arst_n clears counters and valid flags at once.
module consensus_column_vote_core
	import ccv_pkg::*;
#(
	parameter int MAX_FAMILY = MAX_FAMILY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [2:0] base_code, [5:3] ref_code, [7:6] zero
	input  logic        s_tlast,   // column_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [2:0] consensus_symbol, [10:3] winning_votes, [15:11] zero
);

	localparam int CW = $clog2(MAX_FAMILY + 1);
	localparam int XW = (CW > 8) ? CW : 8;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FAMILY);

	logic [2:0] base_code;
	logic [2:0] ref_code;
	logic       s_xfer;
	logic       res_valid;

	logic [CW-1:0] cnt_q   [VOTE_COUNT];
	logic [CW-1:0] cnt_nxt [VOTE_COUNT];
	logic [CW-1:0] cnt_bias[VOTE_COUNT];
	logic [CW-1:0] mx;
	logic [XW-1:0] mx_x;
	logic [3:0]    bias;       // lanes A, C, G, T
	logic          bias_any;
	logic [2:0]    slot;

	ccv_result_t res;
	ccv_result_t out_q;
	ccv_result_t skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;

	assign base_code = s_tdata[2:0];
	assign ref_code  = s_tdata[5:3];
	assign s_tready  = !skid_valid_q;
	assign s_xfer    = s_tvalid && s_tready;
	assign res_valid = s_xfer && s_tlast;

	// unused code 7 counts as an N vote
	assign slot = (base_code == 3'd7) ? 3'(VOTE_N) : base_code;

	// per-lane saturating increment
	always_comb begin
		for (int k = 0; k < VOTE_COUNT; k++) begin
			cnt_nxt[k] = cnt_q[k];
			if (slot == 3'(k) && cnt_q[k] != CNT_MAX) begin
				cnt_nxt[k] = cnt_q[k] + CW'(1);
			end
		end
	end

	always_comb begin
		mx = '0;
		for (int k = 0; k < VOTE_COUNT; k++) begin
			if (cnt_nxt[k] > mx) begin
				mx = cnt_nxt[k];
			end
		end
	end

	// reference bias: only a winning reference base suppresses its rivals
	assign bias[VOTE_A] = (ref_code == REF_A) && (cnt_nxt[VOTE_A] == mx);
	assign bias[VOTE_C] = (ref_code == REF_C) && (cnt_nxt[VOTE_C] == mx);
	assign bias[VOTE_G] = (ref_code == REF_G) && (cnt_nxt[VOTE_G] == mx);
	assign bias[VOTE_T] = (ref_code == REF_T) && (cnt_nxt[VOTE_T] == mx);
	assign bias_any     = |bias;

	always_comb begin
		for (int k = 0; k < VOTE_COUNT; k++) begin
			cnt_bias[k] = cnt_nxt[k];
		end
		for (int k = VOTE_A; k <= VOTE_T; k++) begin
			if (bias_any && !bias[k]) begin
				cnt_bias[k] = '0;
			end
		end
		if (bias_any) begin
			cnt_bias[VOTE_D] = '0;
		end
	end

	assign mx_x = XW'(mx);

	always_comb begin
		res.winning_votes = (mx_x > XW'(255)) ? 8'hFF : mx_x[7:0];
		priority if (cnt_bias[VOTE_I] == mx) begin
			res.consensus_symbol = SYM_GAP;
		end else if (cnt_bias[VOTE_G] == mx) begin
			res.consensus_symbol = SYM_G;
		end else if (cnt_bias[VOTE_C] == mx) begin
			res.consensus_symbol = SYM_C;
		end else if (cnt_bias[VOTE_T] == mx) begin
			res.consensus_symbol = SYM_T;
		end else if (cnt_bias[VOTE_A] == mx) begin
			res.consensus_symbol = SYM_A;
		end else if (cnt_bias[VOTE_D] == mx) begin
			res.consensus_symbol = SYM_GAP;
		end else begin
			res.consensus_symbol = SYM_N;
		end
	end

	// counters clear after every column end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VOTE_COUNT; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (s_xfer) begin
			for (int k = 0; k < VOTE_COUNT; k++) begin
				cnt_q[k] <= s_tlast ? '0 : cnt_nxt[k];
			end
		end
	end

	// result register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (m_tready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_q.winning_votes, out_q.consensus_symbol};

	// the skid register is only ever filled behind a stalled result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while the output is empty");

	// m_tvalid is always high in the cycle after a column end is taken
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> m_tvalid)
		else $error("column end without a result");

	// counters are clear after a column end
	a_counters_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=>
		(cnt_q[VOTE_A] == '0 && cnt_q[VOTE_C] == '0 && cnt_q[VOTE_G] == '0 &&
		 cnt_q[VOTE_T] == '0 && cnt_q[VOTE_N] == '0 && cnt_q[VOTE_D] == '0 &&
		 cnt_q[VOTE_I] == '0))
		else $error("vote counters not cleared after column end");

	// every column holds at least one vote
	a_votes_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[10:3] != 8'd0))
		else $error("result with zero winning votes");

endmodule
